// ===== rtl/core/lrukv_pkg.sv =====
package lrukv_pkg;

  localparam int unsigned CAPACITY_DEF  = 64;
  localparam int unsigned KEY_W_DEF     = 32;
  localparam int unsigned VALUE_W_DEF   = 32;

  localparam int unsigned KIND_W        = 2;
  localparam int unsigned CFG_W         = 7;
  localparam int unsigned OCC_W         = 7;
  localparam int unsigned APB_DW        = 32;
  localparam int unsigned APB_AW        = 3;

  localparam logic [CFG_W-1:0] LIMIT_RESET = 7'd50;

  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  // register index taken from paddr[2]
  localparam logic REG_CAP_LIMIT = 1'b0;

  typedef struct packed {
    logic cmp;    // capture key compare
    logic shift;  // take neighbour's entry
  } lrukv_cell_ctl_t;

endpackage

// ===== rtl/core/lrukv_cell.sv =====
module lrukv_cell #(
  parameter int unsigned KEY_WIDTH   = lrukv_pkg::KEY_W_DEF,
  parameter int unsigned VALUE_WIDTH = lrukv_pkg::VALUE_W_DEF
) (
  input  logic                         clk_i,
  input  lrukv_pkg::lrukv_cell_ctl_t   ctl_i,
  input  logic                         valid_i,
  input  logic [KEY_WIDTH-1:0]         srch_key_i,
  input  logic [KEY_WIDTH-1:0]         prev_key_i,
  input  logic [VALUE_WIDTH-1:0]       prev_value_i,
  output logic [KEY_WIDTH-1:0]         key_o,
  output logic [VALUE_WIDTH-1:0]       value_o,
  output logic                         match_o
);

  logic [KEY_WIDTH-1:0]   key_q;
  logic [VALUE_WIDTH-1:0] value_q;
  logic                   match_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.cmp) begin
      match_q <= valid_i && (key_q == srch_key_i);
    end
    if (ctl_i.shift) begin
      key_q   <= prev_key_i;
      value_q <= prev_value_i;
    end
  end

  assign key_o   = key_q;
  assign value_o = value_q;
  assign match_o = match_q;

endmodule

// ===== rtl/core/lru_key_value_cache.sv =====
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tuser: kind; tdata: key, value
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: hit, value_out, evicted,
//                                               evicted_key, occupancy
// apb       in   psel/penable/pwrite/pready     capacity_limit at address 0
//
// Each transfer runs a key compare in every cell, select/reduce over
// groups of eight cells, then the shift of the cell row. Entries sit in
// recency order, cell 0 most recent; valid cells are those below the count.
// Reset clears the count and sets the limit to 50; no clearing pass.
// The update cycle waits while the result register is full and not taken;
// a new item is taken in the same cycle the update completes.
module lru_key_value_cache #(
  parameter int unsigned CAPACITY    = lrukv_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_WIDTH   = lrukv_pkg::KEY_W_DEF,
  parameter int unsigned VALUE_WIDTH = lrukv_pkg::VALUE_W_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // key, value
  input  logic [((KEY_WIDTH+VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // kind
  input  logic [lrukv_pkg::KIND_W-1:0]         s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // hit, value_out, evicted, evicted_key, occupancy
  output logic [((VALUE_WIDTH+KEY_WIDTH+2+lrukv_pkg::OCC_W+7)/8)*8-1:0] m_axis_tdata,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [lrukv_pkg::APB_AW-1:0]         paddr,
  input  logic [lrukv_pkg::APB_DW-1:0]         pwdata,
  output logic [lrukv_pkg::APB_DW-1:0]         prdata,
  output logic                                 pready
);

  localparam int unsigned CW     = $clog2(CAPACITY + 1);
  localparam int unsigned NG     = (CAPACITY + 7) / 8;
  localparam int unsigned OUT_W  = ((VALUE_WIDTH + KEY_WIDTH + 2 + lrukv_pkg::OCC_W + 7) / 8) * 8;
  localparam int unsigned OUT_B  = VALUE_WIDTH + KEY_WIDTH + 2 + lrukv_pkg::OCC_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_SEL  = 2'd2;
  localparam logic [1:0] ST_UPD  = 2'd3;

  logic [1:0]                      state_q, state_d;
  logic [lrukv_pkg::CFG_W-1:0]     cfg_q;
  logic [CW-1:0]                   count_q;
  logic [CW-1:0]                   cnt_new_q;
  logic [lrukv_pkg::KIND_W-1:0]    kind_q;
  logic [KEY_WIDTH-1:0]            key_q;
  logic [VALUE_WIDTH-1:0]          value_q;
  logic                            hit_q, ev_q;
  logic [CAPACITY-1:0]             after_q;
  logic [VALUE_WIDTH-1:0]          grp_val_q [NG];
  logic [KEY_WIDTH-1:0]            grp_key_q [NG];
  logic                            out_valid_q;
  logic [OUT_W-1:0]                out_data_q;

  logic                            accept;
  logic                            upd_fire;
  logic                            cfg_wr;
  logic [CW-1:0]                   lim;
  logic [CW-1:0]                   c1;
  logic                            hit_c, ins_hit, ev_c;
  logic [CAPACITY-1:0]             match_vec, valid_vec, after_c, esel_c;
  logic [KEY_WIDTH-1:0]            cell_key [CAPACITY];
  logic [VALUE_WIDTH-1:0]          cell_val [CAPACITY];
  logic [VALUE_WIDTH-1:0]          hit_val;
  logic [KEY_WIDTH-1:0]            ev_key;
  logic [VALUE_WIDTH-1:0]          head_val;
  logic                            shift_kind;
  logic [CW-1:0]                   cnt_new_c;
  logic [VALUE_WIDTH-1:0]          grp_val_d [NG];
  logic [KEY_WIDTH-1:0]            grp_key_d [NG];

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == lrukv_pkg::REG_CAP_LIMIT);
  assign prdata = (paddr[2] == lrukv_pkg::REG_CAP_LIMIT) ?
                  lrukv_pkg::APB_DW'(cfg_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= lrukv_pkg::LIMIT_RESET;
    end else if (cfg_wr) begin
      cfg_q <= pwdata[lrukv_pkg::CFG_W-1:0];
    end
  end

  always_comb begin
    if (cfg_q == '0) begin
      lim = CW'(1);
    end else if (32'(cfg_q) > 32'(CAPACITY)) begin
      lim = CW'(CAPACITY);
    end else begin
      lim = CW'(cfg_q);
    end
  end

  // sequencer
  assign upd_fire      = (state_q == ST_UPD) && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = (state_q == ST_IDLE) || upd_fire;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_CMP;
      ST_CMP:  state_d = ST_SEL;
      ST_SEL:  state_d = ST_UPD;
      ST_UPD: begin
        if (upd_fire) state_d = accept ? ST_CMP : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= s_axis_tuser;
      key_q   <= s_axis_tdata[KEY_WIDTH-1:0];
      value_q <= s_axis_tdata[KEY_WIDTH+VALUE_WIDTH-1:KEY_WIDTH];
    end
  end

  // cell row
  assign head_val   = (kind_q == lrukv_pkg::KIND_INSERT) ? value_q : hit_val;
  assign shift_kind = (kind_q == lrukv_pkg::KIND_INSERT) ||
                      ((kind_q == lrukv_pkg::KIND_LOOKUP) && hit_q);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    lrukv_pkg::lrukv_cell_ctl_t ctl;
    logic [KEY_WIDTH-1:0]       prev_key;
    logic [VALUE_WIDTH-1:0]     prev_val;

    if (i == 0) begin : g_head
      assign prev_key   = key_q;
      assign prev_val   = head_val;
      assign after_c[i] = 1'b0;
      assign ctl.shift  = upd_fire && shift_kind;
    end else begin : g_body
      assign prev_key   = cell_key[i-1];
      assign prev_val   = cell_val[i-1];
      assign after_c[i] = |match_vec[i-1:0];
      assign ctl.shift  = upd_fire && shift_kind && !after_q[i];
    end

    assign ctl.cmp      = (state_q == ST_CMP);
    assign valid_vec[i] = CW'(i) < count_q;
    assign esel_c[i]    = ev_c && valid_vec[i] && !match_vec[i] &&
                          ((CW'(i) - CW'(after_c[i])) == (c1 - CW'(1)));

    lrukv_cell #(
      .KEY_WIDTH   (KEY_WIDTH),
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .valid_i      (valid_vec[i]),
      .srch_key_i   (key_q),
      .prev_key_i   (prev_key),
      .prev_value_i (prev_val),
      .key_o        (cell_key[i]),
      .value_o      (cell_val[i]),
      .match_o      (match_vec[i])
    );
  end

  // select: hit, eviction and new count
  assign hit_c   = ((kind_q == lrukv_pkg::KIND_LOOKUP) ||
                    (kind_q == lrukv_pkg::KIND_INSERT)) && (|match_vec);
  assign ins_hit = (kind_q == lrukv_pkg::KIND_INSERT) && (|match_vec);
  assign c1      = count_q - CW'(ins_hit);
  assign ev_c    = (kind_q == lrukv_pkg::KIND_INSERT) && (c1 != '0) &&
                   ((CW+1)'(c1) + (CW+1)'(1) > (CW+1)'(lim));

  always_comb begin
    case (kind_q)
      lrukv_pkg::KIND_LOOKUP: cnt_new_c = count_q;
      lrukv_pkg::KIND_INSERT: cnt_new_c = c1 - CW'(ev_c) + CW'(1);
      lrukv_pkg::KIND_CLEAR:  cnt_new_c = '0;
      default:                cnt_new_c = count_q;
    endcase
  end

  // first level of the reduction tree: eight cells per group
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_val_d[g] = '0;
      grp_key_d[g] = '0;
      for (int j = 0; j < 8; j++) begin
        if (g * 8 + j < CAPACITY) begin
          if (match_vec[g*8+j]) grp_val_d[g] = grp_val_d[g] | cell_val[g*8+j];
          if (esel_c[g*8+j])    grp_key_d[g] = grp_key_d[g] | cell_key[g*8+j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SEL) begin
      hit_q     <= hit_c;
      ev_q      <= ev_c;
      after_q   <= after_c;
      cnt_new_q <= cnt_new_c;
      for (int g = 0; g < NG; g++) begin
        grp_val_q[g] <= grp_val_d[g];
        grp_key_q[g] <= grp_key_d[g];
      end
    end
  end

  always_comb begin
    hit_val = '0;
    ev_key  = '0;
    for (int g = 0; g < NG; g++) begin
      hit_val = hit_val | grp_val_q[g];
      ev_key  = ev_key | grp_key_q[g];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (upd_fire) begin
      count_q <= cnt_new_q;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (upd_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_fire) begin
      out_data_q <= OUT_W'({lrukv_pkg::OCC_W'(cnt_new_q),
                            (ev_q ? ev_key : {KEY_WIDTH{1'b0}}),
                            ev_q,
                            ((kind_q == lrukv_pkg::KIND_LOOKUP) ? hit_val
                                                                : {VALUE_WIDTH{1'b0}}),
                            hit_q});
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  localparam int unsigned OUT_CHK = OUT_B;

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(CAPACITY))
    else $error("entry count above capacity");

  a_one_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEL) |-> $onehot0(match_vec))
    else $error("key stored in more than one cell");

  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_fire && (kind_q == lrukv_pkg::KIND_CLEAR)) |=> (count_q == '0))
    else $error("clear left entries");

  a_evict_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_fire && ev_q) |-> (kind_q == lrukv_pkg::KIND_INSERT) &&
                           (32'(count_q) >= 32'(lim)))
    else $error("eviction outside a full insert");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(upd_fire) && (OUT_CHK <= OUT_W))
    else $error("result without an update");

endmodule
